/* src/gfsm_pkg.sv */
// Shared constants and types for the gutter fill source map.
`timescale 1ns / 1ps

package gfsm_pkg;

    // Atlas limits
    localparam int MAX_DIM    = 64;
    localparam int MAX_TEXELS = 4096;

    localparam int DIM_W   = $clog2(MAX_DIM + 1);   // holds 0..MAX_DIM
    localparam int COORD_W = $clog2(MAX_DIM);       // column or row
    localparam int IDX_W   = $clog2(MAX_TEXELS);    // flat texel index
    localparam int CNT_W   = IDX_W + 1;             // holds MAX_TEXELS itself
    localparam int ENTRY_W = IDX_W + 1;             // {index, valid}
    localparam int PASS_W  = 4;
    localparam int CFG_W   = 7;

    // Register indexes on the config port
    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_PASSES = 2'd2;

    localparam logic [CFG_W-1:0]  CFG_WIDTH_RST  = CFG_W'(64);
    localparam logic [CFG_W-1:0]  CFG_HEIGHT_RST = CFG_W'(64);
    localparam logic [PASS_W-1:0] CFG_PASSES_RST = PASS_W'(4);

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_MARK   = 2'd1,
        OP_DILATE = 2'd2,
        OP_QUERY  = 2'd3
    } t_op;

    // Address unit modes: mark/query flat index, or one of the four neighbors
    typedef enum logic [2:0] {
        AM_MARK,
        AM_LEFT,
        AM_RIGHT,
        AM_UP,
        AM_DOWN
    } t_addr_mode;

endpackage

/* src/gutter_fill_source_map_top.sv */
// Top level of the gutter fill source map: sequencer, map and snapshot memories.
`timescale 1ns / 1ps

// Gutter fill source map. Keeps one entry per texel of a width x height atlas
// (up to 64 x 64) naming the covered texel that feeds it. Ops come in on the
// slave stream: clear, mark (x,y), dilate, query (x,y); only a query returns
// an item (tuser = found, tdata = source index). The block takes one item at
// a time and drops s_tready until that item is done. After reset the map is
// swept clear one entry per cycle; a clear op does the same sweep. Mark and
// query first register y * w; mark then writes the entry, query reads the map
// and then loads the output register, waiting on m_tready while it is full (a
// result waits in the output register while the next op runs). Dilate runs P
// passes over N = w*h texels (none when P or N is zero): each pass copies the
// map into the snapshot memory, a read then a write per entry, then walks the
// texels, reading self and up to four neighbors through the single snapshot
// read port with one shared address adder. A covered texel stops after its
// self read; an uncovered one reads its in-bounds neighbors left, right, up,
// down until one is covered. Config writes must be made while idle.
module gutter_fill_source_map_top
    import gfsm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config write port
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [6:0]  i_cfg_wdata,
    // op stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [1:0] op, [7:2] x, [13:8] y, [15:14] zero
    // query results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [11:0] source_index, [15:12] zero
    output logic [0:0]  m_tuser    // [0] found
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLR,
        S_MUL,
        S_MARK,
        S_Q_RD,
        S_Q_OUT,
        S_D_INIT,
        S_D_PASS,
        S_CP_RD,
        S_CP_WR,
        S_SC_SELF,
        S_SC_CHK,
        S_SC_NB,
        S_SC_NCHK,
        S_SC_NEXT
    } t_state;

    // ---------------- config ----------------
    logic [CFG_W-1:0]  r_cfg_w, r_cfg_h;
    logic [PASS_W-1:0] r_cfg_pass;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w    <= CFG_WIDTH_RST;
            r_cfg_h    <= CFG_HEIGHT_RST;
            r_cfg_pass <= CFG_PASSES_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_WIDTH:  r_cfg_w    <= i_cfg_wdata;
                CFG_HEIGHT: r_cfg_h    <= i_cfg_wdata;
                CFG_PASSES: r_cfg_pass <= i_cfg_wdata[PASS_W-1:0];
                default:    ;
            endcase
        end
    end

    // saturate to MAX_DIM; 64 x 64 never exceeds MAX_TEXELS, so no height cut
    logic [DIM_W-1:0] w_eff, h_eff;
    assign w_eff = (DIM_W'(r_cfg_w) > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : DIM_W'(r_cfg_w);
    assign h_eff = (DIM_W'(r_cfg_h) > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : DIM_W'(r_cfg_h);

    logic [CNT_W-1:0] r_n;   // texel count, registered from config
    always_ff @(posedge i_clk) begin
        r_n <= CNT_W'(CNT_W'(w_eff) * CNT_W'(h_eff));
    end

    // ---------------- memories ----------------
    logic [ENTRY_W-1:0] r_map_mem  [MAX_TEXELS];
    logic [ENTRY_W-1:0] r_snap_mem [MAX_TEXELS];
    logic [ENTRY_W-1:0] r_map_rd, r_snap_rd;

    logic               map_we, map_re, snap_we, snap_re;
    logic [IDX_W-1:0]   map_waddr, map_raddr, snap_waddr, snap_raddr;
    logic [ENTRY_W-1:0] map_wdata, snap_wdata;

    always_ff @(posedge i_clk) begin
        if (map_we) r_map_mem[map_waddr] <= map_wdata;
        if (map_re) r_map_rd <= r_map_mem[map_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (snap_we) r_snap_mem[snap_waddr] <= snap_wdata;
        if (snap_re) r_snap_rd <= r_snap_mem[snap_raddr];
    end

    // ---------------- sequencer ----------------
    t_state             r_state, n_state;
    t_op                r_op, n_op;
    logic [COORD_W-1:0] r_x, n_x, r_y, n_y;
    logic [CNT_W-1:0]   r_prod, n_prod;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [IDX_W-1:0]   r_t, n_t;
    logic [COORD_W-1:0] r_sx, n_sx, r_sy, n_sy;
    t_addr_mode         r_dir, n_dir;
    logic [PASS_W-1:0]  r_pass_left, n_pass_left;
    logic               r_q_in, n_q_in;
    logic               r_out_valid, n_out_valid;
    logic               r_found, n_found;
    logic [IDX_W-1:0]   r_idx, n_idx;

    // shared address unit
    t_addr_mode         au_mode;
    logic [CNT_W-1:0]   au_base, au_addr;
    logic [COORD_W-1:0] au_x, au_y;
    logic               au_ok;

    logic in_scan;
    assign in_scan = (r_state == S_SC_NB);
    assign au_mode = in_scan ? r_dir : AM_MARK;
    assign au_base = in_scan ? CNT_W'(r_t) : r_prod;
    assign au_x    = in_scan ? r_sx : r_x;
    assign au_y    = in_scan ? r_sy : r_y;

    gfsm_addr_unit u_addr (
        .i_mode (au_mode),
        .i_base (au_base),
        .i_x    (au_x),
        .i_y    (au_y),
        .i_w    (w_eff),
        .i_h    (h_eff),
        .i_n    (r_n),
        .o_addr (au_addr),
        .o_ok   (au_ok)
    );

    function automatic t_addr_mode next_dir(input t_addr_mode d);
        t_addr_mode r;
        case (d)
            AM_LEFT:  r = AM_RIGHT;
            AM_RIGHT: r = AM_UP;
            default:  r = AM_DOWN;
        endcase
        return r;
    endfunction

    assign s_tready = (r_state == S_IDLE);

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_x         = r_x;
        n_y         = r_y;
        n_prod      = r_prod;
        n_cnt       = r_cnt;
        n_t         = r_t;
        n_sx        = r_sx;
        n_sy        = r_sy;
        n_dir       = r_dir;
        n_pass_left = r_pass_left;
        n_q_in      = r_q_in;
        n_out_valid = r_out_valid;
        n_found     = r_found;
        n_idx       = r_idx;

        map_we     = 1'b0;
        map_waddr  = r_cnt[IDX_W-1:0];
        map_wdata  = '0;
        map_re     = 1'b0;
        map_raddr  = r_cnt[IDX_W-1:0];
        snap_we    = 1'b0;
        snap_waddr = r_cnt[IDX_W-1:0];
        snap_wdata = r_map_rd;
        snap_re    = 1'b0;
        snap_raddr = r_t;

        // result taken downstream
        if (r_out_valid && m_tready) n_out_valid = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (s_tvalid) begin
                    n_op = t_op'(s_tdata[1:0]);
                    n_x  = s_tdata[7:2];
                    n_y  = s_tdata[13:8];
                    unique case (t_op'(s_tdata[1:0]))
                        OP_CLEAR: begin
                            n_cnt   = '0;
                            n_state = S_CLR;
                        end
                        OP_DILATE: n_state = S_D_INIT;
                        default:   n_state = S_MUL;
                    endcase
                end
            end
            S_CLR: begin
                map_we = 1'b1;
                if (r_cnt == CNT_W'(MAX_TEXELS - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end
            S_MUL: begin
                n_prod  = CNT_W'(r_y) * CNT_W'(w_eff);
                n_state = (r_op == OP_MARK) ? S_MARK : S_Q_RD;
            end
            S_MARK: begin
                // only the flat index is bounds-checked
                if (au_ok) begin
                    map_we    = 1'b1;
                    map_waddr = au_addr[IDX_W-1:0];
                    map_wdata = {au_addr[IDX_W-1:0], 1'b1};
                end
                n_state = S_IDLE;
            end
            S_Q_RD: begin
                map_re    = 1'b1;
                map_raddr = au_addr[IDX_W-1:0];
                n_q_in    = (DIM_W'(r_x) < w_eff) && (DIM_W'(r_y) < h_eff);
                n_state   = S_Q_OUT;
            end
            S_Q_OUT: begin
                if (!r_out_valid || m_tready) begin
                    n_out_valid = 1'b1;
                    n_found     = r_q_in & r_map_rd[0];
                    n_idx       = (r_q_in & r_map_rd[0]) ? r_map_rd[ENTRY_W-1:1] : '0;
                    n_state     = S_IDLE;
                end
            end
            S_D_INIT: begin
                n_pass_left = r_cfg_pass;
                n_state     = S_D_PASS;
            end
            S_D_PASS: begin
                if (r_pass_left == '0 || r_n == '0) begin
                    n_state = S_IDLE;
                end else begin
                    n_cnt   = '0;
                    n_state = S_CP_RD;
                end
            end
            S_CP_RD: begin
                map_re  = 1'b1;
                n_state = S_CP_WR;
            end
            S_CP_WR: begin
                snap_we = 1'b1;
                if (r_cnt == r_n - CNT_W'(1)) begin
                    n_t     = '0;
                    n_sx    = '0;
                    n_sy    = '0;
                    n_state = S_SC_SELF;
                end else begin
                    n_cnt   = r_cnt + CNT_W'(1);
                    n_state = S_CP_RD;
                end
            end
            S_SC_SELF: begin
                snap_re = 1'b1;
                n_state = S_SC_CHK;
            end
            S_SC_CHK: begin
                if (r_snap_rd[0]) begin
                    n_state = S_SC_NEXT;
                end else begin
                    n_dir   = AM_LEFT;
                    n_state = S_SC_NB;
                end
            end
            S_SC_NB: begin
                if (au_ok) begin
                    snap_re    = 1'b1;
                    snap_raddr = au_addr[IDX_W-1:0];
                    n_state    = S_SC_NCHK;
                end else if (r_dir == AM_DOWN) begin
                    n_state = S_SC_NEXT;
                end else begin
                    n_dir = next_dir(r_dir);
                end
            end
            S_SC_NCHK: begin
                if (r_snap_rd[0]) begin
                    map_we    = 1'b1;
                    map_waddr = r_t;
                    map_wdata = r_snap_rd;
                    n_state   = S_SC_NEXT;
                end else if (r_dir == AM_DOWN) begin
                    n_state = S_SC_NEXT;
                end else begin
                    n_dir   = next_dir(r_dir);
                    n_state = S_SC_NB;
                end
            end
            S_SC_NEXT: begin
                if (CNT_W'(r_t) == r_n - CNT_W'(1)) begin
                    n_pass_left = r_pass_left - PASS_W'(1);
                    n_state     = S_D_PASS;
                end else begin
                    n_t = r_t + IDX_W'(1);
                    if (DIM_W'(r_sx) + DIM_W'(1) == w_eff) begin
                        n_sx = '0;
                        n_sy = r_sy + COORD_W'(1);
                    end else begin
                        n_sx = r_sx + COORD_W'(1);
                    end
                    n_state = S_SC_SELF;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;   // sweep the map clear after reset
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            r_pass_left <= '0;
            r_dir       <= AM_LEFT;
            r_op        <= OP_CLEAR;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
            r_pass_left <= n_pass_left;
            r_dir       <= n_dir;
            r_op        <= n_op;
        end
        r_x     <= n_x;
        r_y     <= n_y;
        r_prod  <= n_prod;
        r_t     <= n_t;
        r_sx    <= n_sx;
        r_sy    <= n_sy;
        r_q_in  <= n_q_in;
        r_found <= n_found;
        r_idx   <= n_idx;
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = 16'(r_idx);
    assign m_tuser  = r_found;

endmodule

/* src/gfsm_addr_unit.sv */
// Shared add/subtract unit: flat texel index and neighbor addresses with bounds.
`timescale 1ns / 1ps

module gfsm_addr_unit
    import gfsm_pkg::*;
(
    input  t_addr_mode         i_mode,
    input  logic [CNT_W-1:0]   i_base,
    input  logic [COORD_W-1:0] i_x,
    input  logic [COORD_W-1:0] i_y,
    input  logic [DIM_W-1:0]   i_w,
    input  logic [DIM_W-1:0]   i_h,
    input  logic [CNT_W-1:0]   i_n,
    output logic [CNT_W-1:0]   o_addr,
    output logic               o_ok
);

    logic [CNT_W-1:0] opnd;
    logic             sub;

    always_comb begin
        opnd = CNT_W'(1);
        sub  = 1'b0;
        case (i_mode)
            AM_MARK:  opnd = CNT_W'(i_x);
            AM_LEFT:  sub  = 1'b1;
            AM_RIGHT: opnd = CNT_W'(1);
            AM_UP: begin
                opnd = CNT_W'(i_w);
                sub  = 1'b1;
            end
            AM_DOWN:  opnd = CNT_W'(i_w);
            default:  opnd = CNT_W'(1);
        endcase
    end

    // the one adder
    assign o_addr = sub ? (i_base - opnd) : (i_base + opnd);

    always_comb begin
        case (i_mode)
            AM_MARK:  o_ok = (o_addr < i_n);
            AM_LEFT:  o_ok = (i_x != '0);
            AM_RIGHT: o_ok = ((DIM_W'(i_x) + DIM_W'(1)) < i_w);
            AM_UP:    o_ok = (i_y != '0);
            AM_DOWN:  o_ok = ((DIM_W'(i_y) + DIM_W'(1)) < i_h);
            default:  o_ok = 1'b0;
        endcase
    end

endmodule

/* dv/tb_gutter_fill_source_map_top.sv */
// Testbench for the gutter fill source map: directed and random ops checked against a predictor.
`timescale 1ns / 1ps

module tb_gutter_fill_source_map_top;
    import gfsm_pkg::*;

    localparam int HALF_PERIOD_NS = 4;
    localparam int RANDOM_ITEMS   = 650;
    localparam int SETTLE_CYCLES  = 16;
    // Longest quiet stretch of a correct run is a 64x64, 4 pass dilate.
    localparam int QUIET_LIMIT    = 1_000_000;
    // Random dilates only on atlases this small, so each stays short.
    localparam int DILATE_MAX_N   = 256;

    // one op item, packed the way s_tdata carries it (op in the low bits)
    typedef struct packed {
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] x;
        t_op                op;
    } t_op_item;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] source_index;
    } t_lookup;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_PATTERN
    } t_rx_mode;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_we    = 1'b0;
    logic [1:0]  i_cfg_addr  = CFG_WIDTH;
    logic [6:0]  i_cfg_wdata = '0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata     = '0;   // [1:0] op, [7:2] x, [13:8] y, [15:14] zero
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [15:0] m_tdata;            // [11:0] source_index, [15:12] zero
    logic [0:0]  m_tuser;            // [0] found

    gutter_fill_source_map_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    always #HALF_PERIOD_NS i_clk = ~i_clk;

    // Predictor state: mirrored registers, source map and per-pass snapshot.
    logic [CFG_W-1:0]  cfg_width;
    logic [CFG_W-1:0]  cfg_height;
    logic [PASS_W-1:0] cfg_passes;
    logic              src_valid  [MAX_TEXELS];
    logic [IDX_W-1:0]  src_index  [MAX_TEXELS];
    logic              snap_valid [MAX_TEXELS];
    logic [IDX_W-1:0]  snap_index [MAX_TEXELS];

    t_op_item op_queue[$];
    t_lookup  expected_lookups[$];
    t_op_item cur_op;
    int       ops_pushed   = 0;
    int       ops_accepted = 0;
    int       mismatches   = 0;
    int       quiet_cycles = 0;
    int       burst_left   = 0;
    int       gap_left     = 0;
    t_rx_mode rx_mode      = RX_OPEN;
    int       rx_left      = 0;
    int       rx_tick      = 0;

    // Width in use: saturates at MAX_DIM.
    function automatic int clip_width();
        int w;
        w = int'(cfg_width);
        if (w > MAX_DIM) w = MAX_DIM;
        if (w > MAX_TEXELS) w = MAX_TEXELS;
        return w;
    endfunction

    // Height in use: saturates at MAX_DIM and is cut so w*h fits the map.
    function automatic int clip_height(input int w);
        int h;
        h = int'(cfg_height);
        if (h > MAX_DIM) h = MAX_DIM;
        if (w != 0 && h > MAX_TEXELS / w) h = MAX_TEXELS / w;
        return h;
    endfunction

    // Applies one accepted op to the predicted map; a query queues its lookup.
    task automatic track_op(input t_op_item it);
        int      w, h, n, t, p, xx, yy, nb;
        t_lookup res;
        w = clip_width();
        h = clip_height(w);
        n = w * h;
        case (it.op)
            OP_CLEAR: begin
                for (t = 0; t < MAX_TEXELS; t++) src_valid[t] = 1'b0;
            end
            OP_MARK: begin
                // only the flat index is bounded, so x past the row end wraps
                t = int'(it.y) * w + int'(it.x);
                if (t < n) begin
                    src_valid[t] = 1'b1;
                    src_index[t] = IDX_W'(t);
                end
            end
            OP_DILATE: begin
                for (p = 0; p < int'(cfg_passes); p++) begin
                    for (t = 0; t < n; t++) begin
                        snap_valid[t] = src_valid[t];
                        snap_index[t] = src_index[t];
                    end
                    for (yy = 0; yy < h; yy++) begin
                        for (xx = 0; xx < w; xx++) begin
                            t  = yy * w + xx;
                            nb = -1;
                            // first covered neighbor wins: left, right, up, down
                            if (!snap_valid[t]) begin
                                if (xx > 0 && snap_valid[t - 1]) nb = t - 1;
                                else if (xx + 1 < w && snap_valid[t + 1]) nb = t + 1;
                                else if (yy > 0 && snap_valid[t - w]) nb = t - w;
                                else if (yy + 1 < h && snap_valid[t + w]) nb = t + w;
                            end
                            if (nb >= 0) begin
                                src_valid[t] = 1'b1;
                                src_index[t] = snap_index[nb];
                            end
                        end
                    end
                end
            end
            default: begin
                res = '0;
                if (int'(it.x) < w && int'(it.y) < h) begin
                    t = int'(it.y) * w + int'(it.x);
                    res.found        = src_valid[t];
                    res.source_index = src_valid[t] ? src_index[t] : '0;
                end
                expected_lookups.push_back(res);
            end
        endcase
    endtask

    task automatic push_op(input t_op op, input int x, input int y);
        t_op_item it;
        it.op = op;
        it.x  = COORD_W'(x);
        it.y  = COORD_W'(y);
        op_queue.push_back(it);
        ops_pushed++;
    endtask

    // Sender holds off until every op is taken and every lookup has come back.
    task automatic settle();
        while (ops_accepted != ops_pushed || expected_lookups.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Writes all three registers; only called while the block is idle.
    task automatic set_config(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                              input logic [PASS_W-1:0] p);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= CFG_WIDTH;
        i_cfg_wdata <= w;
        @(posedge i_clk);
        i_cfg_addr  <= CFG_HEIGHT;
        i_cfg_wdata <= h;
        @(posedge i_clk);
        i_cfg_addr  <= CFG_PASSES;
        i_cfg_wdata <= CFG_W'(p);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cfg_width  = w;
        cfg_height = h;
        cfg_passes = p;
    endtask

    // Mostly inside the atlas in use, sometimes anywhere in the field range.
    function automatic int pick_coord(input int dim);
        if (dim > 0 && $urandom_range(0, 4) != 0) return $urandom_range(0, dim - 1);
        return $urandom_range(0, (1 << COORD_W) - 1);
    endfunction

    function automatic logic [CFG_W-1:0] dim_extreme();
        case ($urandom_range(0, 3))
            0:       return CFG_W'(1);
            1:       return CFG_W'(MAX_DIM);
            2:       return '1;
            default: return '0;
        endcase
    endfunction

    // Op driver: bursts of random length with random gaps in between.
    always @(posedge i_clk) begin : op_driver
        t_op_item nxt;
        logic     nxt_valid;
        nxt       = cur_op;
        nxt_valid = s_tvalid;
        if (!i_rst_n) begin
            nxt.op    = OP_CLEAR;
            nxt.x     = '0;
            nxt.y     = '0;
            nxt_valid = 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                track_op(cur_op);
                ops_accepted++;
                nxt_valid = 1'b0;
            end
            if (!nxt_valid) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (op_queue.size() != 0) begin
                    nxt       = op_queue.pop_front();
                    nxt_valid = 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end
            end
        end
        cur_op   <= nxt;
        s_tvalid <= nxt_valid;
        s_tdata  <= {2'b00, nxt};
    end

    // Result sink: wide open, coin flip, or short ready windows, switching at random.
    always @(posedge i_clk) begin : result_sink
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (rx_left == 0) begin
                rx_mode = t_rx_mode'($urandom_range(0, 2));
                rx_left = $urandom_range(8, 64);
            end else begin
                rx_left--;
            end
            rx_tick++;
            case (rx_mode)
                RX_OPEN: m_tready <= 1'b1;
                RX_COIN: m_tready <= 1'($urandom_range(0, 1));
                default: m_tready <= (rx_tick % 7) < 2;
            endcase
        end
    end

    always @(posedge i_clk) begin : result_check
        t_lookup want, got;
        if (i_rst_n && m_tvalid && m_tready) begin
            got.found        = m_tuser[0];
            got.source_index = m_tdata[IDX_W-1:0];
            if (expected_lookups.size() == 0) begin
                $error("query result with none outstanding: found=%0d source_index=%0d",
                       got.found, got.source_index);
                mismatches++;
            end else begin
                want = expected_lookups.pop_front();
                if (want.found !== got.found) begin
                    $error("found: expected %0d, actual %0d", want.found, got.found);
                    mismatches++;
                end
                if (want.source_index !== got.source_index) begin
                    $error("source_index: expected %0d, actual %0d",
                           want.source_index, got.source_index);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: cycles with no item moving on either stream.
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
    end

    initial begin : watchdog
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("end of test: mismatches");
        $finish;
    end

    initial begin : stimulus
        int               t, budget, len, i, r, wd, hd;
        logic             may_dilate;
        logic [CFG_W-1:0] w_cfg, h_cfg;
        logic [PASS_W-1:0] p_cfg;

        cfg_width  = CFG_WIDTH_RST;
        cfg_height = CFG_HEIGHT_RST;
        cfg_passes = CFG_PASSES_RST;
        for (t = 0; t < MAX_TEXELS; t++) begin
            src_valid[t] = 1'b0;
            src_index[t] = '0;
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings, full 64x64 atlas: corners and an interior texel.
        push_op(OP_MARK, 0, 0);
        push_op(OP_MARK, 63, 63);
        push_op(OP_MARK, 10, 5);
        push_op(OP_QUERY, 0, 0);
        push_op(OP_QUERY, 63, 63);
        push_op(OP_QUERY, 1, 0);
        settle();
        push_op(OP_DILATE, 0, 0);
        push_op(OP_QUERY, 1, 0);
        push_op(OP_QUERY, 62, 63);
        push_op(OP_QUERY, 10, 3);
        push_op(OP_QUERY, 32, 32);
        settle();

        // 5x4, most passes: column past the row end, index past the atlas,
        // queries outside in x and in y.
        set_config(7'd5, 7'd4, '1);
        push_op(OP_CLEAR, 0, 0);
        push_op(OP_MARK, 7, 0);
        push_op(OP_MARK, 0, 5);
        push_op(OP_DILATE, 0, 0);
        push_op(OP_QUERY, 2, 1);
        push_op(OP_QUERY, 4, 3);
        push_op(OP_QUERY, 5, 0);
        push_op(OP_QUERY, 0, 4);
        settle();

        // zero width: empty atlas
        set_config(7'd0, 7'd64, 4'd1);
        push_op(OP_MARK, 0, 0);
        push_op(OP_DILATE, 0, 0);
        push_op(OP_QUERY, 0, 0);
        settle();

        // oversize dims saturate; old entries read under the new width, zero passes
        set_config('1, '1, '0);
        push_op(OP_QUERY, 7, 0);
        push_op(OP_QUERY, 19, 0);
        push_op(OP_DILATE, 0, 0);
        push_op(OP_QUERY, 20, 0);
        settle();

        // Random phases: a setting, maybe a clear, then marks, dilates and
        // queries; each phase ends on a query so the block is idle after it.
        budget = 0;
        while (budget < RANDOM_ITEMS) begin
            r = $urandom_range(0, 9);
            p_cfg = PASS_W'($urandom_range(0, 15));
            if (r <= 5) begin
                w_cfg = CFG_W'($urandom_range(1, 16));
                h_cfg = CFG_W'($urandom_range(1, 16));
            end else if (r == 6) begin
                w_cfg = CFG_W'($urandom_range(1, MAX_DIM));
                h_cfg = CFG_W'($urandom_range(1, MAX_DIM));
            end else if (r == 7) begin
                w_cfg = CFG_W'($urandom_range(MAX_DIM + 1, 127));
                h_cfg = CFG_W'($urandom_range(0, 127));
            end else if (r == 8) begin
                w_cfg = $urandom_range(0, 1) ? CFG_W'(0) : CFG_W'($urandom_range(1, 127));
                h_cfg = (w_cfg != 0) ? CFG_W'(0) : CFG_W'($urandom_range(0, 127));
            end else begin
                w_cfg = dim_extreme();
                h_cfg = dim_extreme();
                p_cfg = $urandom_range(0, 1) ? '1 : '0;
            end
            set_config(w_cfg, h_cfg, p_cfg);
            wd = clip_width();
            hd = clip_height(wd);
            may_dilate = (wd * hd <= DILATE_MAX_N);

            if ($urandom_range(0, 1)) push_op(OP_CLEAR, 0, 0);
            len = $urandom_range(15, 50);
            for (i = 0; i < len; i++) begin
                r = $urandom_range(0, 99);
                if (r < 2) push_op(OP_CLEAR, $urandom_range(0, 63), $urandom_range(0, 63));
                else if (r < 32) push_op(OP_MARK, pick_coord(wd), pick_coord(hd));
                else if (r < 37 && may_dilate)
                    push_op(OP_DILATE, $urandom_range(0, 63), $urandom_range(0, 63));
                else push_op(OP_QUERY, pick_coord(wd), pick_coord(hd));
            end
            push_op(OP_QUERY, pick_coord(wd), pick_coord(hd));
            budget += len + 1;
            settle();
        end

        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

/* gutter_fill_source_map_top.f */
src/gfsm_pkg.sv
src/gfsm_addr_unit.sv
src/gutter_fill_source_map_top.sv
dv/tb_gutter_fill_source_map_top.sv
